FILE: rtl/core/lsr_pkg.sv
package lsr_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;

   localparam int X_W     = 7;
   localparam int Y_W     = 6;
   localparam int COORD_W = 7;
   // decision term stays within -2*dmajor .. 2*dminor
   localparam int D_W     = COORD_W + 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [X_W-1:0] X_MAX = X_W'(SCREEN_WIDTH - 1);
   localparam logic [Y_W-1:0] Y_MAX = Y_W'(SCREEN_HEIGHT - 1);

   typedef struct packed {
      logic                     steep;
      logic [COORD_W-1:0]       ma0;
      logic [COORD_W-1:0]       ma1;
      logic [COORD_W-1:0]       mi0;
      logic [COORD_W-1:0]       dmaj;
      logic [COORD_W-1:0]       dmin;
      logic                     step_neg;
      logic signed [D_W-1:0]    d0;
   } lsr_job_type;

endpackage

FILE: rtl/core/lsr_front.sv
module lsr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [lsr_pkg::X_W-1:0]   req_start_x,
   input  logic [lsr_pkg::Y_W-1:0]   req_start_y,
   input  logic [lsr_pkg::X_W-1:0]   req_end_x,
   input  logic [lsr_pkg::Y_W-1:0]   req_end_y,
   input  logic                      q_full,
   output logic                      push,
   output lsr_pkg::lsr_job_type      push_job
);
   import lsr_pkg::*;

   logic                job_valid_ff, job_valid_in;
   lsr_job_type         job_ff, job_in;
   logic                accept;

   logic [X_W-1:0]      x0, x1;
   logic [Y_W-1:0]      y0, y1;
   logic [X_W-1:0]      adx;
   logic [Y_W-1:0]      ady;
   logic                steep;
   logic [COORD_W-1:0]  a0, a1, b0, b1;
   logic [COORD_W-1:0]  ma0, ma1, mi0, mi1;
   logic [COORD_W-1:0]  dmin;

   assign push   = job_valid_ff & ~q_full;
   assign busy   = job_valid_ff & q_full;
   assign accept = start & ~busy;
   assign push_job = job_ff;

   always_comb begin
      x0 = (req_start_x > X_MAX) ? X_MAX : req_start_x;
      x1 = (req_end_x   > X_MAX) ? X_MAX : req_end_x;
      y0 = (req_start_y > Y_MAX) ? Y_MAX : req_start_y;
      y1 = (req_end_y   > Y_MAX) ? Y_MAX : req_end_y;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      steep = ~(COORD_W'(ady) < COORD_W'(adx));
      if (steep) begin
         a0 = COORD_W'(y0); b0 = COORD_W'(x0);
         a1 = COORD_W'(y1); b1 = COORD_W'(x1);
      end else begin
         a0 = COORD_W'(x0); b0 = COORD_W'(y0);
         a1 = COORD_W'(x1); b1 = COORD_W'(y1);
      end
      // order so that the major coordinate increases
      if (a0 > a1) begin
         ma0 = a1; mi0 = b1; ma1 = a0; mi1 = b0;
      end else begin
         ma0 = a0; mi0 = b0; ma1 = a1; mi1 = b1;
      end
      job_in.steep = steep;
      job_in.ma0   = ma0;
      job_in.ma1   = ma1;
      job_in.mi0   = mi0;
      job_in.dmaj  = ma1 - ma0;
      if (mi1 < mi0) begin
         dmin = mi0 - mi1;
         job_in.step_neg = 1'b1;
      end else begin
         dmin = mi1 - mi0;
         job_in.step_neg = 1'b0;
      end
      job_in.dmin = dmin;
      job_in.d0   = signed'({2'b00, dmin, 1'b0}) - signed'({3'b000, ma1 - ma0});
   end

   assign job_valid_in = accept | (job_valid_ff & ~push);

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

FILE: rtl/core/lsr_queue.sv
module lsr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lsr_pkg::lsr_job_type  push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output lsr_pkg::lsr_job_type  head_job
);
   import lsr_pkg::*;

   lsr_job_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/core/lsr_back.sv
module lsr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  lsr_pkg::lsr_job_type          head_job,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic                          rsp_steep_run,
   output logic [lsr_pkg::COORD_W-1:0]   rsp_fixed_coord,
   output logic [lsr_pkg::COORD_W-1:0]   rsp_run_first,
   output logic [lsr_pkg::COORD_W-1:0]   rsp_run_last_pos,
   output logic                          rsp_last_run
);
   import lsr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_STEP = 2'b10
   } lsr_state_type;

   lsr_state_type          state_ff, state_in;
   logic                   steep_ff, steep_in;
   logic                   step_neg_ff, step_neg_in;
   logic [COORD_W-1:0]     major_ff, major_in;
   logic [COORD_W-1:0]     ma1_ff, ma1_in;
   logic [COORD_W-1:0]     minor_ff, minor_in;
   logic [COORD_W-1:0]     run_start_ff, run_start_in;
   logic [COORD_W-1:0]     dmaj_ff, dmaj_in;
   logic [COORD_W-1:0]     dmin_ff, dmin_in;
   logic signed [D_W-1:0]  d_ff, d_in;
   logic signed [D_W-1:0]  dmin2, dmaj2;

   logic                   strobe_ff, strobe_in;
   logic                   out_steep_ff, out_steep_in;
   logic [COORD_W-1:0]     out_fixed_ff, out_fixed_in;
   logic [COORD_W-1:0]     out_first_ff, out_first_in;
   logic [COORD_W-1:0]     out_last_ff, out_last_in;
   logic                   out_final_ff, out_final_in;

   assign dmin2 = signed'({2'b00, dmin_ff, 1'b0});
   assign dmaj2 = signed'({2'b00, dmaj_ff, 1'b0});

   always_comb begin
      state_in     = state_ff;
      steep_in     = steep_ff;
      step_neg_in  = step_neg_ff;
      major_in     = major_ff;
      ma1_in       = ma1_ff;
      minor_in     = minor_ff;
      run_start_in = run_start_ff;
      dmaj_in      = dmaj_ff;
      dmin_in      = dmin_ff;
      d_in         = d_ff;
      pop          = 1'b0;
      strobe_in    = 1'b0;
      out_steep_in = steep_ff;
      out_fixed_in = minor_ff;
      out_first_in = run_start_ff;
      out_last_in  = major_ff;
      out_final_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop          = 1'b1;
               steep_in     = head_job.steep;
               step_neg_in  = head_job.step_neg;
               major_in     = head_job.ma0;
               ma1_in       = head_job.ma1;
               minor_in     = head_job.mi0;
               run_start_in = head_job.ma0;
               dmaj_in      = head_job.dmaj;
               dmin_in      = head_job.dmin;
               d_in         = head_job.d0;
               state_in     = ST_STEP;
            end
         end
         ST_STEP: begin
            if (major_ff == ma1_ff) begin
               strobe_in    = 1'b1;
               out_final_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               if (d_ff > 0) begin
                  // minor coordinate moves: close the current run
                  strobe_in    = 1'b1;
                  minor_in     = step_neg_ff ? minor_ff - 1'b1 : minor_ff + 1'b1;
                  run_start_in = major_ff + 1'b1;
                  d_in         = d_ff + dmin2 - dmaj2;
               end else begin
                  d_in = d_ff + dmin2;
               end
               major_in = major_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff     <= steep_in;
      step_neg_ff  <= step_neg_in;
      major_ff     <= major_in;
      ma1_ff       <= ma1_in;
      minor_ff     <= minor_in;
      run_start_ff <= run_start_in;
      dmaj_ff      <= dmaj_in;
      dmin_ff      <= dmin_in;
      d_ff         <= d_in;
      out_steep_ff <= out_steep_in;
      out_fixed_ff <= out_fixed_in;
      out_first_ff <= out_first_in;
      out_last_ff  <= out_last_in;
      out_final_ff <= out_final_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_steep_run    = out_steep_ff;
   assign rsp_fixed_coord  = out_fixed_ff;
   assign rsp_run_first    = out_first_ff;
   assign rsp_run_last_pos = out_last_ff;
   assign rsp_last_run     = out_final_ff;

endmodule

FILE: rtl/core/line_span_rasterizer.sv
// Bresenham line rasterizer that returns each line as runs of pixels sharing a
// minor coordinate. A line is taken when start is high and busy is low; its
// end points are clamped to the screen, classified (steep or shallow, swapped
// so the major coordinate rises), registered and queued. The stepper then walks
// one major position per cycle, and each run appears on the rsp_ ports for one
// cycle with rsp_strobe high, in the cycle after the step that closes it.
// rsp_last_run marks the final run. Up to two classified lines wait in the
// queue plus one in the front register, so busy rises only when all of them
// are occupied. Results cannot be held off.
module line_span_rasterizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lsr_pkg::X_W-1:0]       req_start_x,
   input  logic [lsr_pkg::Y_W-1:0]       req_start_y,
   input  logic [lsr_pkg::X_W-1:0]       req_end_x,
   input  logic [lsr_pkg::Y_W-1:0]       req_end_y,
   output logic                          rsp_strobe,
   output logic                          rsp_steep_run,
   output logic [lsr_pkg::COORD_W-1:0]   rsp_fixed_coord,
   output logic [lsr_pkg::COORD_W-1:0]   rsp_run_first,
   output logic [lsr_pkg::COORD_W-1:0]   rsp_run_last_pos,
   output logic                          rsp_last_run
);
   import lsr_pkg::*;

   logic          push, q_full, pop, head_valid;
   lsr_job_type   push_job, head_job;

   lsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   lsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lsr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_steep_run    (rsp_steep_run),
      .rsp_fixed_coord  (rsp_fixed_coord),
      .rsp_run_first    (rsp_run_first),
      .rsp_run_last_pos (rsp_run_last_pos),
      .rsp_last_run     (rsp_last_run)
   );

   // a run never runs backwards
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_run_first <= rsp_run_last_pos))
      else $error("run first beyond run last");

   // horizontal runs sit on a screen row
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_steep_run) |-> (rsp_fixed_coord <= COORD_W'(SCREEN_HEIGHT - 1)))
      else $error("row out of screen");

   // no result in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result after reset");

   // busy only while a line waits and the queue is full
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_full)
      else $error("busy without full queue");

endmodule

FILE: dv/line_span_rasterizer_tb.sv
module line_span_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsr_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int TAIL_CYCLES  = 400;
   localparam int RANDOM_LINES = 450;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic               steep;
      logic [COORD_W-1:0] fixed;
      logic [COORD_W-1:0] first;
      logic [COORD_W-1:0] last_pos;
      logic               last_run;
   } pixel_run_type;

   class span_tracker;
      pixel_run_type runs_due[$];
      int lines_noted  = 0;
      int steep_lines  = 0;
      int runs_checked = 0;
      int mismatches   = 0;

      function int clip(int v, int lim);
         return (v > lim - 1) ? lim - 1 : v;
      endfunction

      function void add_run(bit steep, int fixed, int first, int last_pos, bit fin);
         pixel_run_type r;
         r.steep    = steep;
         r.fixed    = COORD_W'(fixed);
         r.first    = COORD_W'(first);
         r.last_pos = COORD_W'(last_pos);
         r.last_run = fin;
         runs_due.push_back(r);
      endfunction

      // bresenham walk along the major axis, one run per minor coordinate
      function void note_line(logic [X_W-1:0] sx, logic [Y_W-1:0] sy,
                              logic [X_W-1:0] ex, logic [Y_W-1:0] ey);
         int x0, y0, x1, y1, adx, ady;
         int ma0, ma1, mi0, mi1, tmp;
         int dmaj, dmin, stp, dterm, minor, first, pos;
         bit steep;
         x0 = clip(int'(sx), SCREEN_WIDTH);
         y0 = clip(int'(sy), SCREEN_HEIGHT);
         x1 = clip(int'(ex), SCREEN_WIDTH);
         y1 = clip(int'(ey), SCREEN_HEIGHT);
         adx = (x1 > x0) ? x1 - x0 : x0 - x1;
         ady = (y1 > y0) ? y1 - y0 : y0 - y1;
         steep = !(ady < adx);
         if (steep) begin
            ma0 = y0; mi0 = x0; ma1 = y1; mi1 = x1;
         end else begin
            ma0 = x0; mi0 = y0; ma1 = x1; mi1 = y1;
         end
         if (ma0 > ma1) begin
            tmp = ma0; ma0 = ma1; ma1 = tmp;
            tmp = mi0; mi0 = mi1; mi1 = tmp;
         end
         dmaj = ma1 - ma0;
         dmin = mi1 - mi0;
         stp  = 1;
         if (dmin < 0) begin
            stp  = -1;
            dmin = -dmin;
         end
         dterm = 2 * dmin - dmaj;
         minor = mi0;
         first = ma0;
         for (pos = ma0; pos <= ma1; pos++) begin
            if (pos == ma1) begin
               add_run(steep, minor, first, pos, 1'b1);
               break;
            end
            if (dterm > 0) begin
               add_run(steep, minor, first, pos, 1'b0);
               minor += stp;
               first  = pos + 1;
               dterm += 2 * (dmin - dmaj);
            end else begin
               dterm += 2 * dmin;
            end
         end
         lines_noted++;
         if (steep) steep_lines++;
      endfunction

      function void flag(string what, pixel_run_type want, pixel_run_type got);
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("%0t %s: expected steep=%0d fixed=%0d first=%0d last=%0d final=%0d,",
                     $realtime, what, want.steep, want.fixed, want.first, want.last_pos,
                     want.last_run);
            $display("   got steep=%0d fixed=%0d first=%0d last=%0d final=%0d",
                     got.steep, got.fixed, got.first, got.last_pos, got.last_run);
         end
      endfunction

      function void check_run(pixel_run_type got);
         pixel_run_type want;
         runs_checked++;
         if (runs_due.size() == 0) begin
            flag("run with no line pending", '0, got);
            return;
         end
         want = runs_due.pop_front();
         if (got.steep !== want.steep || got.fixed !== want.fixed ||
             got.first !== want.first || got.last_pos !== want.last_pos ||
             got.last_run !== want.last_run)
            flag("run mismatch", want, got);
      endfunction

      function void close_out();
         if (runs_due.size() != 0) begin
            mismatches += runs_due.size();
            $display("%0d expected runs never arrived", runs_due.size());
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [X_W-1:0]     req_start_x;
   logic [Y_W-1:0]     req_start_y;
   logic [X_W-1:0]     req_end_x;
   logic [Y_W-1:0]     req_end_y;
   logic               rsp_strobe;
   logic               rsp_steep_run;
   logic [COORD_W-1:0] rsp_fixed_coord;
   logic [COORD_W-1:0] rsp_run_first;
   logic [COORD_W-1:0] rsp_run_last_pos;
   logic               rsp_last_run;

   span_tracker sb;
   bit idle_on = 1'b1;
   int cycle_count = 0;

   line_span_rasterizer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_steep_run    (rsp_steep_run),
      .rsp_fixed_coord  (rsp_fixed_coord),
      .rsp_run_first    (rsp_run_first),
      .rsp_run_last_pos (rsp_run_last_pos),
      .rsp_last_run     (rsp_last_run)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("line_span_rasterizer verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      pixel_run_type seen;
      if (!reset) begin
         if (start && !busy)
            sb.note_line(req_start_x, req_start_y, req_end_x, req_end_y);
         if (rsp_strobe) begin
            seen.steep    = rsp_steep_run;
            seen.fixed    = rsp_fixed_coord;
            seen.first    = rsp_run_first;
            seen.last_pos = rsp_run_last_pos;
            seen.last_run = rsp_last_run;
            sb.check_run(seen);
         end
      end
   end

   // returns at the edge where the transfer happens, start still high
   task automatic send_line(int sx, int sy, int ex, int ey);
      int gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_start_x <= X_W'(sx);
      req_start_y <= Y_W'(sy);
      req_end_x   <= X_W'(ex);
      req_end_y   <= Y_W'(ey);
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_lines();
      start <= 1'b0;
      do @(posedge clock); while (sb.runs_due.size() != 0);
   endtask

   function automatic int near(int base, int span, int top);
      int v;
      v = base + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   function automatic int edge_pick(int top);
      case ($urandom_range(0, 2))
         0: return 0;
         1: return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   task automatic pick_line(output int sx, output int sy, output int ex, output int ey);
      int mode, d;
      mode = $urandom_range(0, 99);
      sx = $urandom_range(0, 127);
      sy = $urandom_range(0, 63);
      ex = $urandom_range(0, 127);
      ey = $urandom_range(0, 63);
      if (mode >= 35 && mode < 65) begin
         // short lines, many runs of length one or two
         ex = near(sx, 6, 127);
         ey = near(sy, 6, 63);
      end else if (mode >= 65 && mode < 72) begin
         ey = sy;
      end else if (mode >= 72 && mode < 79) begin
         ex = sx;
      end else if (mode >= 79 && mode < 86) begin
         // equal slopes
         d  = $urandom_range(0, 63);
         sx = $urandom_range(0, 1) ? $urandom_range(d, 127) : $urandom_range(0, 127 - d);
         ex = (sx >= d && $urandom_range(0, 1)) ? sx - d : ((sx + d <= 127) ? sx + d : sx - d);
         sy = $urandom_range(0, 1) ? $urandom_range(d, 63) : $urandom_range(0, 63 - d);
         ey = (sy >= d && $urandom_range(0, 1)) ? sy - d : ((sy + d <= 63) ? sy + d : sy - d);
      end else if (mode >= 86) begin
         sx = edge_pick(127);
         sy = edge_pick(63);
         ex = edge_pick(127);
         ey = edge_pick(63);
      end
   endtask

   initial begin
      int sx, sy, ex, ey, n;
      sb = new;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_start_x <= '0;
      req_start_y <= '0;
      req_end_x   <= '0;
      req_end_y   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single points, full spans, flat and upright lines, equal slopes
      send_line(0, 0, 0, 0);
      send_line(127, 63, 127, 63);
      send_line(0, 0, 127, 63);
      send_line(127, 63, 0, 0);
      send_line(0, 63, 127, 0);
      send_line(127, 0, 0, 63);
      send_line(0, 5, 127, 5);
      send_line(127, 40, 0, 40);
      send_line(9, 0, 9, 63);
      send_line(9, 63, 9, 0);
      send_line(0, 0, 63, 63);
      send_line(63, 63, 0, 0);
      send_line(10, 40, 50, 0);
      send_line(0, 0, 1, 63);
      send_line(0, 0, 127, 1);
      send_line(5, 5, 6, 5);
      send_line(5, 5, 5, 6);
      send_line(64, 32, 63, 31);
      send_line(127, 0, 0, 0);
      send_line(100, 63, 37, 0);
      drain_lines();

      for (n = 0; n < RANDOM_LINES; n++) begin
         if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (n % 150 == 149) drain_lines();
         pick_line(sx, sy, ex, ey);
         send_line(sx, sy, ex, ey);
      end
      drain_lines();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close_out();

      $display("covered %0d lines (%0d steep, %0d shallow) and %0d pixel runs,",
               sb.lines_noted, sb.steep_lines, sb.lines_noted - sb.steep_lines,
               sb.runs_checked);
      $display("with random idle gaps, back-to-back stretches and full drains; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("line_span_rasterizer verification clean");
      end else begin
         $display("line_span_rasterizer verification failed");
      end
      $finish;
   end
endmodule
